// ===== hw/rtl/mked_pkg.sv =====
`default_nettype none
package mked_pkg;

    localparam int NUM_KEYS_DEF = 4;
    localparam int LEVELS_W     = 4;
    localparam int CKEY_W       = 2;
    localparam int FLAGS_W      = 7;
    localparam int TIMER_W      = 16;
    localparam int DIV_W        = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [DIV_W-1:0]   SAMPLE_DIV_RST   = 8'd20;
    localparam logic [TIMER_W-1:0] DOUBLE_WIN_RST   = 16'd200;
    localparam logic [TIMER_W-1:0] LONG_TIME_RST    = 16'd2000;
    localparam logic [TIMER_W-1:0] REPEAT_INTV_RST  = 16'd100;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DIV  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTV = 2'd3;

    // Input item modes
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    // Event flag masks
    localparam logic [FLAGS_W-1:0] FLAG_HOLD   = 7'h01;
    localparam logic [FLAGS_W-1:0] FLAG_DOWN   = 7'h02;
    localparam logic [FLAGS_W-1:0] FLAG_UP     = 7'h04;
    localparam logic [FLAGS_W-1:0] FLAG_SINGLE = 7'h08;
    localparam logic [FLAGS_W-1:0] FLAG_DOUBLE = 7'h10;
    localparam logic [FLAGS_W-1:0] FLAG_LONG   = 7'h20;
    localparam logic [FLAGS_W-1:0] FLAG_REPEAT = 7'h40;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_PRESS  = 3'd1,
        ST_WAIT   = 3'd2,
        ST_SECOND = 3'd3,
        ST_REPEAT = 3'd4
    } t_stage;

    typedef struct packed {
        logic               level;
        logic               prev;
        t_stage             stage;
        logic [TIMER_W-1:0] timer;
        logic [FLAGS_W-1:0] flags;
    } t_key_st;

    typedef struct packed {
        logic [TIMER_W-1:0] double_win;
        logic [TIMER_W-1:0] long_time;
        logic [TIMER_W-1:0] repeat_intv;
    } t_key_cfg;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_TICK  = 2'd1,
        S_CHECK = 2'd2,
        S_DONE  = 2'd3
    } t_seq;

endpackage
`default_nettype wire

// ===== hw/rtl/mked_in_if.sv =====
`default_nettype none
interface mked_in_if;
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic [mked_pkg::LEVELS_W-1:0]      key_levels;
    logic [mked_pkg::CKEY_W-1:0]        check_key;
    logic [mked_pkg::FLAGS_W-1:0]       check_mask;

    modport source (output valid, mode, key_levels, check_key, check_mask, input ready);
    modport sink   (input valid, mode, key_levels, check_key, check_mask, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mked_out_if.sv =====
`default_nettype none
interface mked_out_if;
    logic                               valid;
    logic                               ready;
    logic                               check_hit;
    logic [mked_pkg::FLAGS_W-1:0]       key_flags;
    logic [mked_pkg::LEVELS_W-1:0]      held_keys;

    modport source (output valid, check_hit, key_flags, held_keys, input ready);
    modport sink   (input valid, check_hit, key_flags, held_keys, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mked_key_step.sv =====
`default_nettype none
module mked_key_step (
    input  mked_pkg::t_key_st  i_key,
    input  mked_pkg::t_key_cfg i_cfg,
    input  logic               i_sample,
    input  logic               i_level,
    output mked_pkg::t_key_st  o_key
);
    import mked_pkg::*;

    logic [TIMER_W-1:0] w_timer;
    logic               w_tmo;

    assign w_timer = (i_key.timer != '0) ? i_key.timer - 1'b1 : i_key.timer;
    assign w_tmo   = (w_timer == '0);

    always_comb begin
        o_key       = i_key;
        o_key.timer = w_timer;
        if (i_sample) begin
            o_key.prev  = i_key.level;
            o_key.level = i_level;
            if (i_level) begin
                o_key.flags = o_key.flags | FLAG_HOLD;
            end else begin
                o_key.flags = o_key.flags & ~FLAG_HOLD;
            end
            if (i_level && !i_key.level) begin
                o_key.flags = o_key.flags | FLAG_DOWN;
            end
            if (!i_level && i_key.level) begin
                o_key.flags = o_key.flags | FLAG_UP;
            end
            case (i_key.stage)
                ST_IDLE: begin
                    if (i_level) begin
                        o_key.timer = i_cfg.long_time;
                        o_key.stage = ST_PRESS;
                    end
                end
                ST_PRESS: begin
                    if (!i_level) begin
                        o_key.timer = i_cfg.double_win;
                        o_key.stage = ST_WAIT;
                    end else if (w_tmo) begin
                        o_key.timer = i_cfg.repeat_intv;
                        o_key.flags = o_key.flags | FLAG_LONG;
                        o_key.stage = ST_REPEAT;
                    end
                end
                ST_WAIT: begin
                    if (i_level) begin
                        o_key.flags = o_key.flags | FLAG_DOUBLE;
                        o_key.stage = ST_SECOND;
                    end else if (w_tmo) begin
                        o_key.flags = o_key.flags | FLAG_SINGLE;
                        o_key.stage = ST_IDLE;
                    end
                end
                ST_SECOND: begin
                    if (!i_level) begin
                        o_key.stage = ST_IDLE;
                    end
                end
                ST_REPEAT: begin
                    if (!i_level) begin
                        o_key.stage = ST_IDLE;
                    end else if (w_tmo) begin
                        o_key.timer = i_cfg.repeat_intv;
                        o_key.flags = o_key.flags | FLAG_REPEAT;
                    end
                end
                default: begin
                    o_key.stage = ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/multi_key_event_detector.sv =====
`default_nettype none
// Debounced event detector for NUM_KEYS push keys. A tick transaction (mode 0) counts every
// key timer down, and on every sample_divider-th tick samples key_levels and updates each
// key's hold/down/up flags and its single/double/long/repeat state machine. A check
// transaction (mode 1) reports the chosen key's flags and whether any masked flag is set,
// then clears the masked flags unless the mask is the hold bit alone. One shared key update
// unit visits the keys one per cycle; a new transaction is accepted once the result is
// registered. Configuration may only be written while the block is idle.
module multi_key_event_detector #(
    parameter int NUM_KEYS = mked_pkg::NUM_KEYS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [mked_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [mked_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    mked_in_if.sink                                i_in,
    mked_out_if.source                             o_out
);
    import mked_pkg::*;

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    t_seq               r_state, n_state;
    logic [DIV_W-1:0]   r_sample_div;
    t_key_cfg           r_cfg;
    logic [DIV_W-1:0]   r_div_cnt;
    logic [DIV_W-1:0]   w_div_inc;
    logic               r_sample;
    logic [LEVELS_W-1:0] r_levels;
    logic [FLAGS_W-1:0] r_mask;
    logic               r_ck_ok;
    logic [KW-1:0]      r_idx, n_idx;
    t_key_st            r_keys [NUM_KEYS];
    t_key_st            w_cur, w_step, w_wdata;
    logic               w_we;
    logic [NUM_KEYS-1:0] w_lvl_vec;
    logic [LEVELS_W-1:0] w_held;
    logic               w_accept;
    logic               w_load;
    logic               w_hit;
    logic               r_res_hit;
    logic [FLAGS_W-1:0] r_res_flags;
    logic               r_out_valid;
    logic               r_out_hit;
    logic [FLAGS_W-1:0] r_out_flags;
    logic [LEVELS_W-1:0] r_out_held;

    assign w_accept  = i_in.valid && i_in.ready;
    assign w_div_inc = r_div_cnt + 1'b1;

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lvl
        if (k < LEVELS_W) begin : g_in
            assign w_lvl_vec[k] = r_levels[k];
        end else begin : g_none
            assign w_lvl_vec[k] = 1'b0;
        end
    end

    for (genvar k = 0; k < LEVELS_W; k++) begin : g_held
        if (k < NUM_KEYS) begin : g_key
            assign w_held[k] = r_keys[k].flags[0];
        end else begin : g_none
            assign w_held[k] = 1'b0;
        end
    end

    assign w_cur = r_keys[r_idx];
    assign w_hit = r_ck_ok && ((w_cur.flags & r_mask) != '0);

    mked_key_step u_step (
        .i_key    (w_cur),
        .i_cfg    (r_cfg),
        .i_sample (r_sample),
        .i_level  (w_lvl_vec[r_idx]),
        .o_key    (w_step)
    );

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        w_we        = 1'b0;
        w_wdata     = w_step;
        w_load      = 1'b0;
        i_in.ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    if (i_in.mode == MODE_TICK) begin
                        n_state = S_TICK;
                        n_idx   = '0;
                    end else begin
                        n_state = S_CHECK;
                        n_idx   = KW'(i_in.check_key);
                    end
                end
            end
            S_TICK: begin
                w_we = 1'b1;
                if (r_idx == KW'(NUM_KEYS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_CHECK: begin
                w_wdata       = w_cur;
                w_wdata.flags = w_cur.flags & ~r_mask;
                w_we          = w_hit && (r_mask != FLAG_HOLD);
                n_state       = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_div      <= SAMPLE_DIV_RST;
            r_cfg.double_win  <= DOUBLE_WIN_RST;
            r_cfg.long_time   <= LONG_TIME_RST;
            r_cfg.repeat_intv <= REPEAT_INTV_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SAMPLE_DIV:  r_sample_div      <= i_cfg_data[DIV_W-1:0];
                CFG_DOUBLE_WIN:  r_cfg.double_win  <= i_cfg_data;
                CFG_LONG_TIME:   r_cfg.long_time   <= i_cfg_data;
                CFG_REPEAT_INTV: r_cfg.repeat_intv <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
            r_sample  <= 1'b0;
        end else if (w_accept && i_in.mode == MODE_TICK) begin
            r_sample  <= (w_div_inc >= r_sample_div);
            r_div_cnt <= (w_div_inc >= r_sample_div) ? '0 : w_div_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_levels <= i_in.key_levels;
            r_mask   <= i_in.check_mask;
            r_ck_ok  <= (i_in.mode == MODE_CHECK) && (int'(i_in.check_key) < NUM_KEYS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_keys[k] <= '0;
            end
        end else if (w_we) begin
            r_keys[r_idx] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_TICK) begin
            r_res_hit   <= 1'b0;
            r_res_flags <= '0;
        end else if (r_state == S_CHECK) begin
            r_res_hit   <= w_hit;
            r_res_flags <= r_ck_ok ? w_cur.flags : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_load) begin
            r_out_hit   <= r_res_hit;
            r_out_flags <= r_res_flags;
            r_out_held  <= w_held;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.check_hit = r_out_hit;
    assign o_out.key_flags = r_out_flags;
    assign o_out.held_keys = r_out_held;

    a_tick_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.mode == MODE_TICK) |=> (r_state == S_TICK && r_idx == '0))
        else $error("tick did not start the key walk at key 0");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK) |-> (int'(r_idx) < NUM_KEYS))
        else $error("key walk index out of range");

    // r_mask still belongs to the reported transaction only while idle
    a_hit_has_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_state == S_IDLE)
            |-> (!o_out.check_hit || (o_out.key_flags & r_mask) != '0))
        else $error("check hit reported without a matching flag");

    a_held_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_state == S_IDLE) |-> (o_out.held_keys[0] == r_keys[0].flags[0]))
        else $error("reported hold state differs from key 0 flags");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mked_pkg::*;

    localparam int KEYS           = NUM_KEYS_DEF;
    localparam int STALL_LIMIT    = 3000;
    localparam int SQUEEZE_AT     = 500;
    localparam int SQUEEZE_CYCLES = 300;

    typedef struct packed {
        logic                mode;
        logic [LEVELS_W-1:0] key_levels;
        logic [CKEY_W-1:0]   check_key;
        logic [FLAGS_W-1:0]  check_mask;
    } key_item_t;

    typedef struct packed {
        logic                check_hit;
        logic [FLAGS_W-1:0]  key_flags;
        logic [LEVELS_W-1:0] held_keys;
    } key_report_t;

    bit                    i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mked_in_if  in_if ();
    mked_out_if out_if ();

    multi_key_event_detector dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // timing settings as the block holds them
    logic [DIV_W-1:0]   div_setting;
    logic [TIMER_W-1:0] double_setting;
    logic [TIMER_W-1:0] long_setting;
    logic [TIMER_W-1:0] repeat_setting;

    // per-key state of the event predictor
    logic [DIV_W-1:0]   pred_div_count;
    logic               pred_level [KEYS];
    logic               pred_prev  [KEYS];
    t_stage             pred_stage [KEYS];
    logic [TIMER_W-1:0] pred_timer [KEYS];
    logic [FLAGS_W-1:0] pred_flags [KEYS];

    key_item_t   pending_items[$];
    key_report_t expected_reports[$];

    bit          in_taken;
    bit          out_taken;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned stall_cycles;

    int unsigned tx_gap;
    int unsigned tx_calm;
    int unsigned rx_gap;
    int unsigned rx_calm;
    int unsigned hold_left;
    bit          squeezed;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic key_report_t predict_key_events(input key_item_t it);
        key_report_t        r;
        logic [FLAGS_W-1:0] f;
        logic               lvl;
        int                 k;
        r = '0;
        if (it.mode == MODE_TICK) begin
            for (k = 0; k < KEYS; k++) begin
                if (pred_timer[k] != 0) begin
                    pred_timer[k] = pred_timer[k] - 1'b1;
                end
            end
            pred_div_count = pred_div_count + 1'b1;
            if (pred_div_count >= div_setting) begin
                pred_div_count = '0;
                for (k = 0; k < KEYS; k++) begin
                    lvl = it.key_levels[k];
                    f = pred_flags[k];
                    pred_prev[k] = pred_level[k];
                    pred_level[k] = lvl;
                    if (lvl) begin
                        f = f | FLAG_HOLD;
                    end else begin
                        f = f & ~FLAG_HOLD;
                    end
                    if (lvl && !pred_prev[k]) f = f | FLAG_DOWN;
                    if (!lvl && pred_prev[k]) f = f | FLAG_UP;
                    case (pred_stage[k])
                        ST_IDLE: begin
                            if (lvl) begin
                                pred_timer[k] = long_setting;
                                pred_stage[k] = ST_PRESS;
                            end
                        end
                        ST_PRESS: begin
                            if (!lvl) begin
                                pred_timer[k] = double_setting;
                                pred_stage[k] = ST_WAIT;
                            end else if (pred_timer[k] == 0) begin
                                pred_timer[k] = repeat_setting;
                                f = f | FLAG_LONG;
                                pred_stage[k] = ST_REPEAT;
                            end
                        end
                        ST_WAIT: begin
                            if (lvl) begin
                                f = f | FLAG_DOUBLE;
                                pred_stage[k] = ST_SECOND;
                            end else if (pred_timer[k] == 0) begin
                                f = f | FLAG_SINGLE;
                                pred_stage[k] = ST_IDLE;
                            end
                        end
                        ST_SECOND: begin
                            if (!lvl) pred_stage[k] = ST_IDLE;
                        end
                        ST_REPEAT: begin
                            if (!lvl) begin
                                pred_stage[k] = ST_IDLE;
                            end else if (pred_timer[k] == 0) begin
                                pred_timer[k] = repeat_setting;
                                f = f | FLAG_REPEAT;
                            end
                        end
                        default: begin
                            pred_stage[k] = ST_IDLE;
                        end
                    endcase
                    pred_flags[k] = f;
                end
            end
        end else begin
            r.key_flags = pred_flags[it.check_key];
            if ((pred_flags[it.check_key] & it.check_mask) != 0) begin
                r.check_hit = 1'b1;
                // a mask of hold alone only peeks
                if (it.check_mask != FLAG_HOLD) begin
                    pred_flags[it.check_key] = pred_flags[it.check_key] & ~it.check_mask;
                end
            end
        end
        for (k = 0; k < KEYS; k++) begin
            r.held_keys[k] = (pred_flags[k] & FLAG_HOLD) != 0;
        end
        return r;
    endfunction

    function automatic key_item_t tick_item(input logic [LEVELS_W-1:0] levels);
        key_item_t it;
        it.mode       = MODE_TICK;
        it.key_levels = levels;
        it.check_key  = CKEY_W'($urandom);
        it.check_mask = FLAGS_W'($urandom);
        return it;
    endfunction

    function automatic key_item_t check_item(input logic [CKEY_W-1:0] key,
                                             input logic [FLAGS_W-1:0] mask);
        key_item_t it;
        it.mode       = MODE_CHECK;
        it.key_levels = LEVELS_W'($urandom);
        it.check_key  = key;
        it.check_mask = mask;
        return it;
    endfunction

    // Mostly press/release patterns held for a while with checks sprinkled in,
    // plus bursts of bare checks and of unrelated levels.
    task automatic queue_key_traffic(input int unsigned count, input int unsigned span);
        int unsigned         made;
        int unsigned         run;
        logic [LEVELS_W-1:0] lv;
        logic [FLAGS_W-1:0]  mask;
        made = 0;
        lv = '0;
        while (made < count) begin
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 8)) begin
                        pending_items.push_back(tick_item(LEVELS_W'($urandom)));
                        made++;
                    end
                end
                1: begin
                    repeat ($urandom_range(1, 4)) begin
                        pending_items.push_back(check_item(CKEY_W'($urandom),
                                                           FLAGS_W'($urandom)));
                        made++;
                    end
                end
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        lv = LEVELS_W'($urandom);
                    end else begin
                        lv[$urandom_range(0, LEVELS_W-1)] ^= 1'b1;
                    end
                    run = $urandom_range(1, span);
                    repeat (run) begin
                        pending_items.push_back(tick_item(lv));
                        made++;
                        if ($urandom_range(0, 5) == 0) begin
                            case ($urandom_range(0, 4))
                                0: mask = FLAG_HOLD;
                                1: mask = FLAGS_W'(1) << $urandom_range(0, FLAGS_W-1);
                                2: mask = '1;
                                3: mask = '0;
                                default: mask = FLAGS_W'($urandom);
                            endcase
                            pending_items.push_back(check_item(CKEY_W'($urandom), mask));
                            made++;
                        end
                    end
                end
            endcase
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (idx)
            CFG_SAMPLE_DIV:  div_setting    = data[DIV_W-1:0];
            CFG_DOUBLE_WIN:  double_setting = data[TIMER_W-1:0];
            CFG_LONG_TIME:   long_setting   = data[TIMER_W-1:0];
            CFG_REPEAT_INTV: repeat_setting = data[TIMER_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_timing(input logic [DIV_W-1:0] div,
                                  input logic [TIMER_W-1:0] dwin,
                                  input logic [TIMER_W-1:0] long_ticks,
                                  input logic [TIMER_W-1:0] rep);
        write_reg(CFG_SAMPLE_DIV, CFG_DATA_W'(div));
        write_reg(CFG_DOUBLE_WIN, dwin);
        write_reg(CFG_LONG_TIME, long_ticks);
        write_reg(CFG_REPEAT_INTV, rep);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_if.valid === 1'b1
               || expected_reports.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        in_if.valid      = 1'b0;
        in_if.mode       = MODE_TICK;
        in_if.key_levels = '0;
        in_if.check_key  = '0;
        in_if.check_mask = '0;
        out_if.ready     = 1'b0;

        div_setting    = SAMPLE_DIV_RST;
        double_setting = DOUBLE_WIN_RST;
        long_setting   = LONG_TIME_RST;
        repeat_setting = REPEAT_INTV_RST;
        pred_div_count = '0;
        for (int k = 0; k < KEYS; k++) begin
            pred_level[k] = 1'b0;
            pred_prev[k]  = 1'b0;
            pred_stage[k] = ST_IDLE;
            pred_timer[k] = '0;
            pred_flags[k] = '0;
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // timing left at its reset values
        queue_key_traffic(150, 60);
        wait_drained();

        program_timing(8'd1, 16'd2, 16'd3, 16'd1);
        pending_items.push_back(check_item(2'd0, '1));
        pending_items.push_back(tick_item(4'hF));
        pending_items.push_back(check_item(2'd0, FLAG_HOLD));
        pending_items.push_back(check_item(2'd0, '0));
        // hold all keys into long press and two repeats
        repeat (5) pending_items.push_back(tick_item(4'hF));
        pending_items.push_back(check_item(2'd1, '1));
        pending_items.push_back(check_item(2'd1, FLAG_HOLD));
        pending_items.push_back(tick_item(4'h0));
        // double press on keys 0 and 2
        pending_items.push_back(tick_item(4'h5));
        pending_items.push_back(tick_item(4'h0));
        pending_items.push_back(tick_item(4'h5));
        pending_items.push_back(tick_item(4'h0));
        // single press on keys 1 and 3, then let the window run out
        pending_items.push_back(tick_item(4'hA));
        repeat (3) pending_items.push_back(tick_item(4'h0));
        pending_items.push_back(check_item(2'd0, FLAG_DOUBLE));
        pending_items.push_back(check_item(2'd2, FLAG_UP | FLAG_DOWN));
        pending_items.push_back(check_item(2'd3, FLAG_SINGLE));
        pending_items.push_back(check_item(2'd3, FLAG_LONG | FLAG_REPEAT));
        pending_items.push_back(check_item(2'd2, '1));
        queue_key_traffic(300, 12);
        wait_drained();

        // divider zero samples on every tick; zero windows fire at once
        program_timing(8'd0, 16'd0, 16'd0, 16'd0);
        queue_key_traffic(250, 6);
        wait_drained();

        program_timing(8'd2, 16'd5, 16'd8, 16'd3);
        queue_key_traffic(300, 30);
        wait_drained();

        program_timing(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_key_traffic(200, 100);
        wait_drained();

        program_timing(8'd3, 16'd1, 16'd12, 16'd2);
        queue_key_traffic(300, 50);
        wait_drained();

        repeat (KEYS + 8) @(posedge i_clk);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    always @(negedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            in_if.valid <= 1'b0;
        end else if (in_if.valid && !in_taken) begin
            // hold the offered transaction until it is taken
        end else if (tx_gap > 0) begin
            in_if.valid <= 1'b0;
            tx_gap--;
        end else if (pending_items.size() != 0) begin
            key_item_t it;
            it = pending_items.pop_front();
            in_if.valid      <= 1'b1;
            in_if.mode       <= it.mode;
            in_if.key_levels <= it.key_levels;
            in_if.check_key  <= it.check_key;
            in_if.check_mask <= it.check_mask;
            if (tx_calm > 0) begin
                tx_calm--;
                tx_gap = 0;
            end else if ($urandom_range(0, 39) == 0) begin
                tx_calm = 24;
                tx_gap = 0;
            end else begin
                tx_gap = $urandom_range(0, 11);
            end
        end else begin
            in_if.valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            out_if.ready <= 1'b0;
        end else if (!squeezed && results_seen >= SQUEEZE_AT) begin
            // back up the block for a long stretch while the sender keeps offering
            squeezed = 1'b1;
            hold_left = SQUEEZE_CYCLES;
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (out_taken) begin
            int unsigned w;
            if (rx_calm > 0) begin
                rx_calm--;
                w = 0;
            end else if ($urandom_range(0, 39) == 0) begin
                rx_calm = 24;
                w = 0;
            end else begin
                w = $urandom_range(0, 11);
            end
            if (w == 0) begin
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= 1'b0;
                rx_gap = w - 1;
            end
        end else if (rx_gap > 0) begin
            rx_gap--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        key_item_t   seen;
        key_report_t got;
        key_report_t want;
        in_taken  <= in_if.valid && in_if.ready;
        out_taken <= out_if.valid && out_if.ready;
        if (i_rst_n === 1'b1) begin
            if (in_if.valid && in_if.ready) begin
                seen.mode       = in_if.mode;
                seen.key_levels = in_if.key_levels;
                seen.check_key  = in_if.check_key;
                seen.check_mask = in_if.check_mask;
                expected_reports.push_back(predict_key_events(seen));
            end
            if (out_if.valid && out_if.ready) begin
                results_seen++;
                got.check_hit = out_if.check_hit;
                got.key_flags = out_if.key_flags;
                got.held_keys = out_if.held_keys;
                if (expected_reports.size() == 0) begin
                    $display("%0t ns: unexpected report: expected none, got hit %0b flags %02h held %h",
                             $time, got.check_hit, got.key_flags, got.held_keys);
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    if (got.check_hit !== want.check_hit) begin
                        $display("%0t ns: check_hit expected %0b, got %0b",
                                 $time, want.check_hit, got.check_hit);
                        mismatches++;
                    end
                    if (got.key_flags !== want.key_flags) begin
                        $display("%0t ns: key_flags expected %02h, got %02h",
                                 $time, want.key_flags, got.key_flags);
                        mismatches++;
                    end
                    if (got.held_keys !== want.held_keys) begin
                        $display("%0t ns: held_keys expected %h, got %h",
                                 $time, want.held_keys, got.held_keys);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, stall_cycles);
            $display("testbench failed");
            $finish;
        end
    end

endmodule
`default_nettype wire
